// ----- sv/assert_macros.svh -----
// Assertion macros used by the sequencer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AMCS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AMCS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/amcs_pkg.sv -----
// Shared types, codes and constants of the modem call and SMS sequencer.
package amcs_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  // Sequencer state codes.
  localparam logic [3:0] MODE_START   = 4'd0;
  localparam logic [3:0] MODE_CLIPW   = 4'd1;
  localparam logic [3:0] MODE_TEXTW   = 4'd2;
  localparam logic [3:0] MODE_NETW    = 4'd3;
  localparam logic [3:0] MODE_IDLE    = 4'd4;
  localparam logic [3:0] MODE_CALLERW = 4'd5;
  localparam logic [3:0] MODE_HANGW   = 4'd6;
  localparam logic [3:0] MODE_CHECK   = 4'd7;
  localparam logic [3:0] MODE_PROMPT  = 4'd8;
  localparam logic [3:0] MODE_ACK     = 4'd9;

  // Modem commands.
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_CLIP_ON    = 3'd1;
  localparam logic [2:0] CMD_TEXT_MODE  = 3'd2;
  localparam logic [2:0] CMD_REG_QUERY  = 3'd3;
  localparam logic [2:0] CMD_HANGUP     = 3'd4;
  localparam logic [2:0] CMD_SMS_HEADER = 3'd5;
  localparam logic [2:0] CMD_MSG_BODY   = 3'd6;

  // System events.
  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_ON_NETWORK  = 2'd1;
  localparam logic [1:0] EV_OFF_NETWORK = 2'd2;
  localparam logic [1:0] EV_CALL_AUTH   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_TIMEOUT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_POLL       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CALLER_ID_WAIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HANGUP_WAIT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROMPT_TIMEOUT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_TIMEOUT    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HANGUP_COOLDOWN = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RECIPIENT_COUNT = 3'd7;

  typedef struct packed {
    logic burst_ready;
    logic has_ok;
    logic has_reg_reply;
    logic reg_registered;
    logic has_caller_id;
    logic caller_in_list;
    logic has_prompt;
    logic has_send_ack;
    logic ring_flag;
    logic sms_request;
    logic tx_busy;
  } tick_t;

  typedef struct packed {
    logic [2:0] command_sent;
    logic [7:0] recipient_index;
    logic [1:0] system_event;
    logic       request_taken;
    logic [3:0] mode_after;
  } result_t;

  typedef struct packed {
    logic [15:0] reply_timeout;
    logic [15:0] idle_poll_interval;
    logic [15:0] caller_id_wait;
    logic [15:0] hangup_wait;
    logic [15:0] prompt_timeout;
    logic [15:0] text_timeout;
    logic [15:0] hangup_cooldown;
    logic [7:0]  recipient_count;
  } cfg_t;

endpackage

// ----- sv/amcs_tick_if.sv -----
// Handshake channel carrying one input tick.
interface amcs_tick_if import amcs_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/amcs_result_if.sv -----
// Handshake channel carrying one sequencer result.
interface amcs_result_if import amcs_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/amcs_cfg.sv -----
// Configuration register bank with reset defaults.
module amcs_cfg import amcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] index,
  input  logic [CFG_DATA_W-1:0]  wdata,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reply_timeout      <= 16'd1000;
      cfg.idle_poll_interval <= 16'd5000;
      cfg.caller_id_wait     <= 16'd2000;
      cfg.hangup_wait        <= 16'd500;
      cfg.prompt_timeout     <= 16'd5000;
      cfg.text_timeout       <= 16'd10000;
      cfg.hangup_cooldown    <= 16'd3000;
      cfg.recipient_count    <= 8'd1;
    end else if (wr_en) begin
      unique case (index)
        REG_REPLY_TIMEOUT:   cfg.reply_timeout      <= wdata;
        REG_IDLE_POLL:       cfg.idle_poll_interval <= wdata;
        REG_CALLER_ID_WAIT:  cfg.caller_id_wait     <= wdata;
        REG_HANGUP_WAIT:     cfg.hangup_wait        <= wdata;
        REG_PROMPT_TIMEOUT:  cfg.prompt_timeout     <= wdata;
        REG_TEXT_TIMEOUT:    cfg.text_timeout       <= wdata;
        REG_HANGUP_COOLDOWN: cfg.hangup_cooldown    <= wdata;
        REG_RECIPIENT_COUNT: cfg.recipient_count    <= wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/amcs_core.sv -----
// Sequencer state registers and the per-tick next-state and result logic.
`include "assert_macros.svh"

module amcs_core import amcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  tick_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [3:0]  mode;
  timer_t      countdown;
  logic [2:0]  deferred;
  logic [7:0]  rpos;
  logic [1:0]  reg_to;
  logic [15:0] cool;
  logic        caller_ok;

  logic [3:0]  mode_next;
  timer_t      countdown_next;
  logic [2:0]  deferred_next;
  logic [7:0]  rpos_next;
  logic [1:0]  reg_to_next;
  logic [15:0] cool_next;
  logic        caller_ok_next;

  logic ok, reg_reply, clip, prompt, ack, busy;
  assign ok        = item.burst_ready & item.has_ok;
  assign reg_reply = item.burst_ready & item.has_reg_reply;
  assign clip      = item.burst_ready & item.has_caller_id;
  assign prompt    = item.burst_ready & item.has_prompt;
  assign ack       = item.burst_ready & item.has_send_ack;
  assign busy      = item.tx_busy;

  logic       timeout;
  timer_t     count_down;
  logic [1:0] reg_to_inc;
  logic [15:0] cool_dec;
  logic [7:0] rpos_inc;
  assign timeout    = (countdown == '0);
  assign count_down = countdown - timer_t'(1);
  assign reg_to_inc = reg_to + 2'd1;
  assign cool_dec   = (cool != 16'd0) ? cool - 16'd1 : cool;
  assign rpos_inc   = rpos + 8'd1;

  always_comb begin
    logic [2:0] mode_cmd;
    logic       went;
    mode_next      = mode;
    countdown_next = countdown;
    deferred_next  = deferred;
    rpos_next      = rpos;
    reg_to_next    = reg_to;
    cool_next      = cool;
    caller_ok_next = caller_ok;
    mode_cmd       = CMD_NONE;
    went           = 1'b0;
    res            = '0;

    // A deferred command goes out first when the transmitter is free.
    if (deferred != CMD_NONE && !busy) begin
      res.command_sent = deferred;
      went             = 1'b1;
      deferred_next    = CMD_NONE;
      if (deferred == CMD_SMS_HEADER || deferred == CMD_MSG_BODY) begin
        res.recipient_index = rpos;
      end
    end

    unique case (mode)
      MODE_CLIPW: begin
        if (ok) begin
          mode_cmd = CMD_TEXT_MODE;
          countdown_next = timer_t'(cfg.reply_timeout);
          mode_next = MODE_TEXTW;
        end else if (timeout) begin
          mode_cmd = CMD_CLIP_ON;
          countdown_next = timer_t'(cfg.reply_timeout);
        end else begin
          countdown_next = count_down;
        end
      end
      MODE_TEXTW: begin
        if (ok) begin
          mode_cmd = CMD_REG_QUERY;
          countdown_next = timer_t'(cfg.reply_timeout);
          mode_next = MODE_NETW;
        end else if (timeout) begin
          mode_cmd = CMD_CLIP_ON;
          countdown_next = timer_t'(cfg.reply_timeout);
          mode_next = MODE_CLIPW;
        end else begin
          countdown_next = count_down;
        end
      end
      MODE_NETW: begin
        if (reg_reply) begin
          reg_to_next = 2'd0;
          if (item.reg_registered) begin
            res.system_event = EV_ON_NETWORK;
            countdown_next = timer_t'(cfg.idle_poll_interval);
            mode_next = MODE_IDLE;
          end else begin
            res.system_event = EV_OFF_NETWORK;
            mode_cmd = CMD_REG_QUERY;
            countdown_next = timer_t'(cfg.reply_timeout);
          end
        end else if (timeout) begin
          // The third missed reply in a row reports loss of network.
          if (reg_to_inc == 2'd3) begin
            reg_to_next = 2'd0;
            res.system_event = EV_OFF_NETWORK;
          end else begin
            reg_to_next = reg_to_inc;
          end
          mode_cmd = CMD_REG_QUERY;
          countdown_next = timer_t'(cfg.reply_timeout);
        end else begin
          countdown_next = count_down;
        end
      end
      MODE_IDLE: begin
        cool_next = cool_dec;
        if (item.ring_flag) begin
          if (clip) begin
            caller_ok_next = item.caller_in_list;
            mode_cmd = CMD_HANGUP;
            countdown_next = timer_t'(cfg.hangup_wait);
            mode_next = MODE_HANGW;
          end else begin
            countdown_next = timer_t'(cfg.caller_id_wait);
            mode_next = MODE_CALLERW;
          end
        end else if (cool_dec == 16'd0 && item.sms_request) begin
          res.request_taken = 1'b1;
          rpos_next = 8'd0;
          mode_cmd = CMD_SMS_HEADER;
          countdown_next = timer_t'(cfg.prompt_timeout);
          mode_next = MODE_PROMPT;
        end else if (timeout) begin
          mode_cmd = CMD_REG_QUERY;
          countdown_next = timer_t'(cfg.reply_timeout);
          mode_next = MODE_NETW;
        end else begin
          countdown_next = count_down;
        end
      end
      MODE_CALLERW: begin
        if (clip || timeout) begin
          // An anonymous caller is never authorized but is still hung up.
          caller_ok_next = clip ? item.caller_in_list : 1'b0;
          mode_cmd = CMD_HANGUP;
          countdown_next = timer_t'(cfg.hangup_wait);
          mode_next = MODE_HANGW;
        end else begin
          countdown_next = count_down;
        end
      end
      MODE_HANGW: begin
        if (ok || timeout) begin
          mode_next = MODE_CHECK;
        end else begin
          countdown_next = count_down;
        end
      end
      MODE_CHECK: begin
        if (caller_ok) begin
          res.system_event = EV_CALL_AUTH;
        end
        caller_ok_next = 1'b0;
        cool_next = cfg.hangup_cooldown;
        countdown_next = timer_t'(cfg.idle_poll_interval);
        mode_next = MODE_IDLE;
      end
      MODE_PROMPT: begin
        if (prompt) begin
          mode_cmd = CMD_MSG_BODY;
          countdown_next = timer_t'(cfg.text_timeout);
          mode_next = MODE_ACK;
        end else if (timeout) begin
          countdown_next = timer_t'(cfg.idle_poll_interval);
          mode_next = MODE_IDLE;
        end else begin
          countdown_next = count_down;
        end
      end
      MODE_ACK: begin
        if (ack && rpos_inc < cfg.recipient_count) begin
          rpos_next = rpos_inc;
          mode_cmd = CMD_SMS_HEADER;
          countdown_next = timer_t'(cfg.prompt_timeout);
          mode_next = MODE_PROMPT;
        end else if (ack || timeout) begin
          countdown_next = timer_t'(cfg.idle_poll_interval);
          mode_next = MODE_IDLE;
        end else begin
          countdown_next = count_down;
        end
      end
      default: begin
        // Start state and unused codes run the init sequence.
        rpos_next = 8'd0;
        reg_to_next = 2'd0;
        cool_next = 16'd0;
        caller_ok_next = 1'b0;
        mode_cmd = CMD_CLIP_ON;
        countdown_next = timer_t'(cfg.reply_timeout);
        mode_next = MODE_CLIPW;
      end
    endcase

    // Only one command leaves per tick; a blocked one replaces the deferred slot.
    if (mode_cmd != CMD_NONE) begin
      if (busy || went) begin
        deferred_next = mode_cmd;
      end else begin
        deferred_next = CMD_NONE;
        res.command_sent = mode_cmd;
        if (mode_cmd == CMD_SMS_HEADER || mode_cmd == CMD_MSG_BODY) begin
          res.recipient_index = rpos_next;
        end
      end
    end

    res.mode_after = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_START;
      countdown <= '0;
      deferred  <= CMD_NONE;
      rpos      <= 8'd0;
      reg_to    <= 2'd0;
      cool      <= 16'd0;
      caller_ok <= 1'b0;
    end else if (step) begin
      mode      <= mode_next;
      countdown <= countdown_next;
      deferred  <= deferred_next;
      rpos      <= rpos_next;
      reg_to    <= reg_to_next;
      cool      <= cool_next;
      caller_ok <= caller_ok_next;
    end
  end

  `AMCS_ASSERT_NOW(a_no_cmd_when_busy, clk, rst, step && res.command_sent != CMD_NONE, !item.tx_busy, "command sent while transmitter busy")
  `AMCS_ASSERT_NOW(a_index_only_sms, clk, rst, res.recipient_index != 8'd0, res.command_sent == CMD_SMS_HEADER || res.command_sent == CMD_MSG_BODY, "recipient index without SMS command")
  `AMCS_ASSERT_NOW(a_auth_from_check, clk, rst, step && res.system_event == EV_CALL_AUTH, mode == MODE_CHECK, "call authorized outside check state")
  `AMCS_ASSERT_NEXT(a_reg_count_bound, clk, rst, step, reg_to != 2'd3, "registration timeout count overflow")

endmodule

// ----- sv/at_modem_call_sms_sequencer.sv -----
// Top level of the modem call and SMS sequencer: input register, core, result register.
//
//   channel  dir  transfer moves                 payload
//   tick     in   one timer tick of modem flags  tick_t
//   result   out  one result per tick            result_t
//   cfg_*    in   one register write             index + 16-bit data
//
// Each tick is captured in an input register, runs through the next-state
// logic of the core, and lands in a result register. A new tick is taken
// every cycle while the result is not stalled; a result becomes valid
// when it is written into the result register. Reset clears the sequencer
// to its start state and empties both registers. A stalled result holds
// the result register, which in turn holds the input register, so one
// tick can wait behind an untaken result.
module at_modem_call_sms_sequencer import amcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  amcs_tick_if.sink              tick,
  amcs_result_if.source          result,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  logic    in_valid;
  tick_t   in_item;
  logic    step;
  result_t step_res;
  logic    out_valid;
  result_t out_data;

  amcs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // The held tick advances when the result register is empty or being drained.
  assign step       = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_item <= tick.data;
    end
  end

  amcs_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= step_res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the modem call and SMS sequencer.
`timescale 1ns / 100ps

module testbench;
  import amcs_pkg::*;

  // The run is cut off here whatever happens. The slowest correct run is about
  // 2000 ticks plus one long output stall, so this is many times over.
  localparam int CYCLE_LIMIT = 200000;

  // Single-bit masks for building ticks by hand. The order follows tick_t,
  // burst_ready in the top bit down to tx_busy in bit zero.
  localparam tick_t F_NONE   = 11'b000_0000_0000;
  localparam tick_t F_BURST  = 11'b100_0000_0000;
  localparam tick_t F_OK     = 11'b010_0000_0000;
  localparam tick_t F_REG    = 11'b001_0000_0000;
  localparam tick_t F_REGD   = 11'b000_1000_0000;
  localparam tick_t F_CLIP   = 11'b000_0100_0000;
  localparam tick_t F_LISTED = 11'b000_0010_0000;
  localparam tick_t F_PROMPT = 11'b000_0001_0000;
  localparam tick_t F_ACK    = 11'b000_0000_1000;
  localparam tick_t F_RING   = 11'b000_0000_0100;
  localparam tick_t F_SMS    = 11'b000_0000_0010;
  localparam tick_t F_BUSY   = 11'b000_0000_0001;
  localparam tick_t F_ALL    = 11'b111_1111_1111;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  amcs_tick_if   tick_ch ();
  amcs_result_if result_ch ();

  at_modem_call_sms_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Idling knobs, in percent of cycles. The sender knob is read by send_tick,
  // the receiver knob by the result receiver process.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_request;

  // Results predicted for accepted ticks, oldest first.
  result_t expected_results[$];

  int unsigned error_count;
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned cycle_count;
  int unsigned calls_authorized;
  int unsigned sms_texts_seen;
  int unsigned off_network_seen;
  int unsigned requests_taken;

  // Our own copy of the sequencer: settings and state. These only change when
  // a tick transfer is seen by send_tick, or when settings are written.
  cfg_t        settings;
  logic [3:0]  seq_mode;
  timer_t      seq_count;
  logic [2:0]  held_cmd;
  logic [7:0]  seq_rpos;
  logic [1:0]  reg_misses;
  logic [15:0] cooldown_left;
  logic        caller_ok;

  // Per-tick scratch for the command slot: whether the transmitter was busy,
  // whether a command already went out, and what went out.
  logic        slot_busy;
  logic        slot_used;
  logic [2:0]  slot_cmd;
  logic [7:0]  slot_idx;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                 expected_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 30) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // One modem command per tick. A command that finds the transmitter busy, or
  // the slot already taken this tick, is held back and replaces whatever was
  // held before.
  function automatic void send_cmd(input logic [2:0] cmd);
    if (slot_busy || slot_used) begin
      held_cmd = cmd;
    end else begin
      held_cmd  = CMD_NONE;
      slot_used = 1'b1;
      slot_cmd  = cmd;
      slot_idx  = (cmd == CMD_SMS_HEADER || cmd == CMD_MSG_BODY) ? seq_rpos : 8'd0;
    end
  endfunction

  // Advances our copy of the sequencer by one tick and returns the result
  // that the block must produce for it.
  function automatic result_t advance_sequencer(input tick_t t);
    logic    ok;
    logic    reg_reply;
    logic    clip;
    logic    prompt;
    logic    ack;
    result_t r;
    // The reply flags only count when a burst actually arrived.
    ok        = t.burst_ready & t.has_ok;
    reg_reply = t.burst_ready & t.has_reg_reply;
    clip      = t.burst_ready & t.has_caller_id;
    prompt    = t.burst_ready & t.has_prompt;
    ack       = t.burst_ready & t.has_send_ack;
    r         = '0;
    slot_busy = t.tx_busy;
    slot_used = 1'b0;
    slot_cmd  = CMD_NONE;
    slot_idx  = 8'd0;

    // A held command goes first whenever the transmitter is free.
    if (held_cmd != CMD_NONE && !t.tx_busy) begin
      send_cmd(held_cmd);
    end

    case (seq_mode)
      MODE_CLIPW: begin
        if (ok) begin
          send_cmd(CMD_TEXT_MODE);
          seq_count = settings.reply_timeout;
          seq_mode  = MODE_TEXTW;
        end else if (seq_count == 0) begin
          send_cmd(CMD_CLIP_ON);
          seq_count = settings.reply_timeout;
        end else begin
          seq_count--;
        end
      end
      MODE_TEXTW: begin
        if (ok) begin
          send_cmd(CMD_REG_QUERY);
          seq_count = settings.reply_timeout;
          seq_mode  = MODE_NETW;
        end else if (seq_count == 0) begin
          send_cmd(CMD_CLIP_ON);
          seq_count = settings.reply_timeout;
          seq_mode  = MODE_CLIPW;
        end else begin
          seq_count--;
        end
      end
      MODE_NETW: begin
        if (reg_reply) begin
          reg_misses = 2'd0;
          if (t.reg_registered) begin
            r.system_event = EV_ON_NETWORK;
            seq_count      = settings.idle_poll_interval;
            seq_mode       = MODE_IDLE;
          end else begin
            r.system_event = EV_OFF_NETWORK;
            send_cmd(CMD_REG_QUERY);
            seq_count = settings.reply_timeout;
          end
        end else if (seq_count == 0) begin
          // The third missed reply in a row reports loss of network.
          reg_misses = reg_misses + 2'd1;
          if (reg_misses == 2'd3) begin
            reg_misses     = 2'd0;
            r.system_event = EV_OFF_NETWORK;
          end
          send_cmd(CMD_REG_QUERY);
          seq_count = settings.reply_timeout;
        end else begin
          seq_count--;
        end
      end
      MODE_IDLE: begin
        if (cooldown_left != 0) begin
          cooldown_left--;
        end
        // A ring beats an SMS request; requests wait out the cooldown.
        if (t.ring_flag) begin
          if (clip) begin
            caller_ok = t.caller_in_list;
            send_cmd(CMD_HANGUP);
            seq_count = settings.hangup_wait;
            seq_mode  = MODE_HANGW;
          end else begin
            seq_count = settings.caller_id_wait;
            seq_mode  = MODE_CALLERW;
          end
        end else if (cooldown_left == 0 && t.sms_request) begin
          r.request_taken = 1'b1;
          seq_rpos        = 8'd0;
          send_cmd(CMD_SMS_HEADER);
          seq_count = settings.prompt_timeout;
          seq_mode  = MODE_PROMPT;
        end else if (seq_count == 0) begin
          send_cmd(CMD_REG_QUERY);
          seq_count = settings.reply_timeout;
          seq_mode  = MODE_NETW;
        end else begin
          seq_count--;
        end
      end
      MODE_CALLERW: begin
        if (clip) begin
          caller_ok = t.caller_in_list;
          send_cmd(CMD_HANGUP);
          seq_count = settings.hangup_wait;
          seq_mode  = MODE_HANGW;
        end else if (seq_count == 0) begin
          // No caller report in time: treat the call as anonymous.
          caller_ok = 1'b0;
          send_cmd(CMD_HANGUP);
          seq_count = settings.hangup_wait;
          seq_mode  = MODE_HANGW;
        end else begin
          seq_count--;
        end
      end
      MODE_HANGW: begin
        if (ok || seq_count == 0) begin
          seq_mode = MODE_CHECK;
        end else begin
          seq_count--;
        end
      end
      MODE_CHECK: begin
        if (caller_ok) begin
          r.system_event = EV_CALL_AUTH;
        end
        caller_ok     = 1'b0;
        cooldown_left = settings.hangup_cooldown;
        seq_count     = settings.idle_poll_interval;
        seq_mode      = MODE_IDLE;
      end
      MODE_PROMPT: begin
        if (prompt) begin
          send_cmd(CMD_MSG_BODY);
          seq_count = settings.text_timeout;
          seq_mode  = MODE_ACK;
        end else if (seq_count == 0) begin
          seq_count = settings.idle_poll_interval;
          seq_mode  = MODE_IDLE;
        end else begin
          seq_count--;
        end
      end
      MODE_ACK: begin
        if (ack) begin
          // The recipient position wraps at eight bits before the compare.
          if (seq_rpos + 8'd1 < settings.recipient_count) begin
            seq_rpos = seq_rpos + 8'd1;
            send_cmd(CMD_SMS_HEADER);
            seq_count = settings.prompt_timeout;
            seq_mode  = MODE_PROMPT;
          end else begin
            seq_count = settings.idle_poll_interval;
            seq_mode  = MODE_IDLE;
          end
        end else if (seq_count == 0) begin
          seq_count = settings.idle_poll_interval;
          seq_mode  = MODE_IDLE;
        end else begin
          seq_count--;
        end
      end
      default: begin
        // Start state, and any unknown code, runs the init sequence.
        seq_count     = '0;
        seq_rpos      = 8'd0;
        reg_misses    = 2'd0;
        held_cmd      = CMD_NONE;
        cooldown_left = 16'd0;
        caller_ok     = 1'b0;
        send_cmd(CMD_CLIP_ON);
        seq_count = settings.reply_timeout;
        seq_mode  = MODE_CLIPW;
      end
    endcase

    r.command_sent    = slot_cmd;
    r.recipient_index = slot_idx;
    r.mode_after      = seq_mode;
    return r;
  endfunction

  // Offers one tick, holding it until the block takes it. Ready is looked at
  // on the falling edge, where everything driven at the rising edge has
  // settled, so a high ready there means the transfer happens at the next
  // rising edge. Valid stays high on return, so back-to-back ticks never see
  // it drop; it only goes low for a sender gap or through stop_ticks.
  task automatic send_tick(input tick_t t);
    bit taken;
    while (chance(send_gap_pct)) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    do begin
      @(negedge clk);
      taken = tick_ch.ready;
      @(posedge clk);
    end while (!taken);
    expected_results.push_back(advance_sequencer(t));
    ticks_sent++;
  endtask

  task automatic stop_ticks();
    tick_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted result has come back, then waits on so that
  // the two-stage pipeline drains.
  task automatic wait_quiet();
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes all eight registers back to back. Only called while the block is
  // quiet, so our copy can take the new settings at once.
  task automatic program_timers(input cfg_t c);
    write_reg(REG_REPLY_TIMEOUT,   c.reply_timeout);
    write_reg(REG_IDLE_POLL,       c.idle_poll_interval);
    write_reg(REG_CALLER_ID_WAIT,  c.caller_id_wait);
    write_reg(REG_HANGUP_WAIT,     c.hangup_wait);
    write_reg(REG_PROMPT_TIMEOUT,  c.prompt_timeout);
    write_reg(REG_TEXT_TIMEOUT,    c.text_timeout);
    write_reg(REG_HANGUP_COOLDOWN, c.hangup_cooldown);
    write_reg(REG_RECIPIENT_COUNT, {8'd0, c.recipient_count});
    cfg_wr_en <= 1'b0;
    settings = c;
  endtask

  // Short timeouts so that every wait can expire within a few ticks, and a
  // handful of recipients so that the send loop goes round.
  function automatic cfg_t random_settings();
    cfg_t c;
    c.reply_timeout      = 16'($urandom_range(6));
    c.idle_poll_interval = 16'($urandom_range(10));
    c.caller_id_wait     = 16'($urandom_range(6));
    c.hangup_wait        = 16'($urandom_range(4));
    c.prompt_timeout     = 16'($urandom_range(6));
    c.text_timeout       = 16'($urandom_range(6));
    c.hangup_cooldown    = 16'($urandom_range(15));
    c.recipient_count    = 8'($urandom_range(5));
    return c;
  endfunction

  // Builds a random tick. Most ticks are shaped to the current state and often
  // carry the reply it is waiting for, so the sequencer gets through setup,
  // registration, calls and message sending; the rest are plain noise on every bit.
  function automatic tick_t shape_tick();
    tick_t       t;
    logic [10:0] noise;
    noise = 11'($urandom_range(2047));
    t     = noise;
    if (chance(80)) begin
      t                = F_NONE;
      t.tx_busy        = chance(15);
      t.reg_registered = chance(50);
      t.caller_in_list = chance(50);
      case (seq_mode)
        MODE_CLIPW, MODE_TEXTW, MODE_HANGW: begin
          if (chance(50)) begin
            t.burst_ready = 1'b1;
            t.has_ok      = 1'b1;
          end
        end
        MODE_NETW: begin
          if (chance(50)) begin
            t.burst_ready    = 1'b1;
            t.has_reg_reply  = 1'b1;
            t.reg_registered = chance(70);
          end
        end
        MODE_IDLE: begin
          t.ring_flag   = chance(12);
          t.sms_request = chance(40);
          if (t.ring_flag && chance(40)) begin
            t.burst_ready   = 1'b1;
            t.has_caller_id = 1'b1;
          end
        end
        MODE_CALLERW: begin
          if (chance(40)) begin
            t.burst_ready   = 1'b1;
            t.has_caller_id = 1'b1;
          end
        end
        MODE_PROMPT: begin
          if (chance(55)) begin
            t.burst_ready = 1'b1;
            t.has_prompt  = 1'b1;
          end
        end
        MODE_ACK: begin
          if (chance(55)) begin
            t.burst_ready  = 1'b1;
            t.has_send_ack = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    return t;
  endfunction

  // The output side: stalls at the chosen rate, or for a long stretch when a
  // hold-off is requested. The hold-off is counted here, in cycles.
  initial begin : result_receiver
    int unsigned hold_off_left;
    hold_off_left   = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        hold_off_left    = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_off_left != 0) begin
        hold_off_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !chance(recv_stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d: %s is %0d, expected %0d", results_checked, name,
                           got, want));
    end
  endtask

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : result_checker
    result_t got;
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result %h arrived with no tick waiting for it", got));
      end else begin
        want = expected_results.pop_front();
        compare_field("command_sent", 8'(got.command_sent), 8'(want.command_sent));
        compare_field("recipient_index", got.recipient_index, want.recipient_index);
        compare_field("system_event", 8'(got.system_event), 8'(want.system_event));
        compare_field("request_taken", 8'(got.request_taken), 8'(want.request_taken));
        compare_field("mode_after", 8'(got.mode_after), 8'(want.mode_after));
        if (want.system_event == EV_CALL_AUTH) calls_authorized++;
        if (want.system_event == EV_OFF_NETWORK) off_network_seen++;
        if (want.command_sent == CMD_MSG_BODY) sms_texts_seen++;
        if (want.request_taken) requests_taken++;
      end
      results_checked++;
    end
  end

  // Walks the sequencer by hand through setup, registration, an anonymous
  // call, a two-recipient broadcast and a whitelisted call, with the
  // transmitter busy at the points where commands must be held back. Short
  // timeouts let each wait expire within a tick or two.
  task automatic test_directed_flow();
    cfg_t c;
    c.reply_timeout      = 16'd2;
    c.idle_poll_interval = 16'd3;
    c.caller_id_wait     = 16'd1;
    c.hangup_wait        = 16'd1;
    c.prompt_timeout     = 16'd2;
    c.text_timeout       = 16'd2;
    c.hangup_cooldown    = 16'd2;
    c.recipient_count    = 8'd2;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    program_timers(c);
    send_tick(F_NONE);                        // start: caller-id on
    send_tick(F_BUSY);                        // busy, countdown runs
    send_tick(F_BURST | F_OK | F_BUSY);       // text mode held back
    send_tick(F_NONE);                        // held command goes out
    send_tick(F_BURST | F_OK);                // registration query
    send_tick(F_BURST | F_REG);               // not registered: off network
    send_tick(F_BURST | F_REG | F_REGD);      // registered: on network, idle
    send_tick(F_RING | F_SMS);                // ring wins over the request
    send_tick(F_NONE);
    send_tick(F_NONE);                        // no caller report: anonymous hang-up
    send_tick(F_BURST | F_OK);                // hang-up acknowledged
    send_tick(F_NONE);                        // check, cooldown starts
    send_tick(F_SMS);                         // still cooling down
    send_tick(F_SMS);                         // request taken, first header
    send_tick(F_BURST | F_PROMPT);
    send_tick(F_BURST | F_ACK);               // second recipient
    send_tick(F_BURST | F_PROMPT | F_BUSY);   // text held back
    send_tick(F_BURST | F_ACK | F_BUSY);      // last recipient done
    // The held text goes out, so the hang-up for this call is held in turn.
    send_tick(F_RING | F_BURST | F_CLIP | F_LISTED);
    send_tick(F_NONE);
    send_tick(F_NONE);
    send_tick(F_NONE);                        // check: call authorized
    send_tick(F_ALL);
    send_tick(F_OK | F_PROMPT | F_ACK | F_REG | F_CLIP);  // flags without a burst
    stop_ticks();
    wait_quiet();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned gap,
                                     input int unsigned stall);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    program_timers(random_settings());
    repeat (count) send_tick(shape_tick());
    stop_ticks();
    wait_quiet();
  endtask

  // All-ones settings never let a wait expire and allow 255 recipients;
  // all-zero settings make every wait expire at once and stop after the first recipient.
  task automatic test_setting_extremes();
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    program_timers('1);
    repeat (80) send_tick(shape_tick());
    stop_ticks();
    wait_quiet();
    program_timers('0);
    repeat (80) send_tick(shape_tick());
    stop_ticks();
    wait_quiet();
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so the
  // pipeline fills and the block has to stall its input.
  task automatic test_output_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    program_timers(random_settings());
    hold_off_request = 250;
    repeat (60) send_tick(shape_tick());
    stop_ticks();
    wait_quiet();
  endtask

  initial begin : run
    rst              = 1'b1;
    tick_ch.valid    = 1'b0;
    tick_ch.data     = F_NONE;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_REPLY_TIMEOUT;
    cfg_wdata        = '0;
    send_gap_pct     = 0;
    recv_stall_pct   = 0;
    hold_off_request = 0;
    error_count      = 0;
    ticks_sent       = 0;
    results_checked  = 0;
    calls_authorized = 0;
    sms_texts_seen   = 0;
    off_network_seen = 0;
    requests_taken   = 0;

    // Our copy starts where the block starts after reset.
    settings.reply_timeout      = 16'd1000;
    settings.idle_poll_interval = 16'd5000;
    settings.caller_id_wait     = 16'd2000;
    settings.hangup_wait        = 16'd500;
    settings.prompt_timeout     = 16'd5000;
    settings.text_timeout       = 16'd10000;
    settings.hangup_cooldown    = 16'd3000;
    settings.recipient_count    = 8'd1;
    seq_mode      = MODE_START;
    seq_count     = '0;
    held_cmd      = CMD_NONE;
    seq_rpos      = 8'd0;
    reg_misses    = 2'd0;
    cooldown_left = 16'd0;
    caller_ok     = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_flow();
    test_random_traffic(550, 8, 74);
    test_random_traffic(550, 74, 8);
    test_random_traffic(400, 0, 0);
    test_setting_extremes();
    test_output_backpressure();

    wait_quiet();
    if (expected_results.size() != 0) begin
      flag_error($sformatf("%0d predicted results never arrived", expected_results.size()));
    end

    $display("Ran %0d ticks through directed, random, extreme-setting and stall phases;",
             ticks_sent);
    $display("checked %0d results: %0d authorized calls, %0d off-network events, %0d SMS %s",
             results_checked, calls_authorized, off_network_seen, sms_texts_seen,
             $sformatf("texts, %0d requests taken.", requests_taken));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
